### sv/assert_macros.svh
// assertion helpers for the pixel format blit block
// used by the top level only; expects clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle (consequent may hold a delay)
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rpfb_pkg.sv
// shared types, register codes and helpers for the pixel format blit block
// no dependencies
`default_nettype none

package rpfb_pkg;

  // largest frame side honored; larger width or height registers clip here too
  localparam int unsigned MAX_DIM = 4096;

  // divide by 255: (x * RECIP_255) >> RECIP_SHIFT is exact for 16-bit x
  localparam logic [15:0] RECIP_255   = 16'd32897;
  localparam int unsigned RECIP_SHIFT = 23;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RED_LAYOUT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LAYOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_LAYOUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BYTES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DST_PITCH    = 3'd6;

  // legal destination pixel sizes
  localparam logic [2:0] BYTES_24BPP = 3'd3;
  localparam logic [2:0] BYTES_32BPP = 3'd4;

  typedef struct packed {
    logic [31:0] pixel;
    logic [11:0] col;
    logic [11:0] row;
  } px_item_t;

  typedef struct packed {
    logic [31:0] packed_res;
    logic [27:0] byte_offset;
  } px_result_t;

  typedef struct packed {
    logic [8:0]  red_layout;
    logic [8:0]  green_layout;
    logic [8:0]  blue_layout;
    logic [2:0]  out_bytes;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [15:0] dst_pitch;
  } cfg_t;

  // channel full-scale value 2^size - 1, size saturated at eight
  function automatic logic [7:0] chan_maxv(input logic [8:0] layout);
    logic [3:0] sz;
    logic [8:0] full;
    sz = (layout[8:5] > 4'd8) ? 4'd8 : layout[8:5];
    full = (9'd1 << sz) - 9'd1;
    return full[7:0];
  endfunction

endpackage

`default_nettype wire

### sv/rpfb_chan.sv
// one color channel: scale 8 bits to the channel size and move it into place
// three register stages; uses rpfb_pkg
`default_nettype none

module rpfb_chan (
  input  wire logic        clk,
  input  wire logic [7:0]  value,
  input  wire logic [8:0]  layout,
  output logic      [31:0] placed
);

  logic [15:0] prod;
  logic [4:0]  shift1;
  logic [7:0]  quot;
  logic [4:0]  shift2;
  logic [31:0] recip_full;

  // stage 1: value times full scale
  always_ff @(posedge clk) begin
    prod   <= 16'(value * rpfb_pkg::chan_maxv(layout));
    shift1 <= layout[4:0];
  end

  // stage 2: divide by 255 through the reciprocal
  assign recip_full = prod * rpfb_pkg::RECIP_255;

  always_ff @(posedge clk) begin
    quot   <= recip_full[rpfb_pkg::RECIP_SHIFT +: 8];
    shift2 <= shift1;
  end

  // stage 3: move to the channel position, bits past 31 drop off
  always_ff @(posedge clk) begin
    placed <= {24'd0, quot} << shift2;
  end

endmodule

`default_nettype wire

### sv/rpfb_offs.sv
// destination byte offset row * pitch + col * bytes
// three register stages; no package dependency, pitch and bytes come from the top level config
`default_nettype none

module rpfb_offs (
  input  wire logic        clk,
  input  wire logic [11:0] row,
  input  wire logic [11:0] col,
  input  wire logic [15:0] pitch,
  input  wire logic [2:0]  bytes,
  output logic      [27:0] offset
);

  logic [27:0] row_part;
  logic [14:0] col_part;
  logic [28:0] sum;
  logic [27:0] offset_mid;

  // stage 1: both products
  always_ff @(posedge clk) begin
    row_part <= row * pitch;
    col_part <= col * bytes;
  end

  // stage 2: add, keep 28 bits
  assign sum = {1'b0, row_part} + {14'd0, col_part};

  always_ff @(posedge clk) begin
    offset_mid <= sum[27:0];
  end

  // stage 3: align with the channel path
  always_ff @(posedge clk) begin
    offset <= offset_mid;
  end

endmodule

`default_nettype wire

### sv/rgb_pixel_format_blit.sv
// XRGB8888 to channel-mask pixel converter with frame clipping
// top level; uses rpfb_pkg, rpfb_chan, rpfb_offs and assert_macros.svh
`default_nettype none

// One pixel is taken per clock whenever start is high and busy is low; busy
// is high only around reset. A pixel inside the frame gives its result on
// done after three stages of channel scaling (multiply by the full-scale
// value, multiply by the reciprocal of 255, shift into place) and the
// output register where the channels are merged. The receiver cannot
// stall, so the result is there for exactly that one cycle. Clipped pixels,
// and every pixel while out_bytes is neither 3 nor 4, give no result.
// Configuration writes are always ready and must only come while no pixel
// is in flight.

`include "assert_macros.svh"

module rgb_pixel_format_blit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire rpfb_pkg::px_item_t                  item,
  output logic                                     done,
  output rpfb_pkg::px_result_t                     result,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rpfb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rpfb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rpfb_pkg::cfg_t cfg;
  logic           accept;
  logic           bytes_ok;
  logic           col_in;
  logic           row_in;
  logic           keep;
  logic [2:0]     valid_pipe;
  logic [31:0]    red_placed;
  logic [31:0]    green_placed;
  logic [31:0]    blue_placed;
  logic [31:0]    merged;
  logic [27:0]    offset;

  // busy only while coming out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_layout   <= 9'd272;
      cfg.green_layout <= 9'd264;
      cfg.blue_layout  <= 9'd256;
      cfg.out_bytes    <= rpfb_pkg::BYTES_32BPP;
      cfg.frame_width  <= 13'd640;
      cfg.frame_height <= 13'd480;
      cfg.dst_pitch    <= 16'd2560;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpfb_pkg::REG_RED_LAYOUT:   cfg.red_layout   <= cfg_data[8:0];
        rpfb_pkg::REG_GREEN_LAYOUT: cfg.green_layout <= cfg_data[8:0];
        rpfb_pkg::REG_BLUE_LAYOUT:  cfg.blue_layout  <= cfg_data[8:0];
        rpfb_pkg::REG_OUT_BYTES:    cfg.out_bytes    <= cfg_data[2:0];
        rpfb_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[12:0];
        rpfb_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[12:0];
        rpfb_pkg::REG_DST_PITCH:    cfg.dst_pitch    <= cfg_data;
        default: ;
      endcase
    end
  end

  // clipping against the frame, the largest frame side and the pixel size
  assign bytes_ok = (cfg.out_bytes == rpfb_pkg::BYTES_24BPP) ||
                    (cfg.out_bytes == rpfb_pkg::BYTES_32BPP);
  assign col_in   = ({1'b0, item.col} < cfg.frame_width) &&
                    (32'(item.col) < rpfb_pkg::MAX_DIM);
  assign row_in   = ({1'b0, item.row} < cfg.frame_height) &&
                    (32'(item.row) < rpfb_pkg::MAX_DIM);
  assign keep     = bytes_ok && col_in && row_in;

  // valid bits alongside the datapath stages
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
      done       <= 1'b0;
    end else begin
      valid_pipe <= {valid_pipe[1:0], accept && keep};
      done       <= valid_pipe[2];
    end
  end

  rpfb_chan u_red (
    .clk    (clk),
    .value  (item.pixel[23:16]),
    .layout (cfg.red_layout),
    .placed (red_placed)
  );

  rpfb_chan u_green (
    .clk    (clk),
    .value  (item.pixel[15:8]),
    .layout (cfg.green_layout),
    .placed (green_placed)
  );

  rpfb_chan u_blue (
    .clk    (clk),
    .value  (item.pixel[7:0]),
    .layout (cfg.blue_layout),
    .placed (blue_placed)
  );

  rpfb_offs u_offs (
    .clk    (clk),
    .row    (item.row),
    .col    (item.col),
    .pitch  (cfg.dst_pitch),
    .bytes  (cfg.out_bytes),
    .offset (offset)
  );

  // merge channels, 24 bpp keeps only the low three bytes
  always_comb begin
    merged = red_placed | green_placed | blue_placed;
    if (cfg.out_bytes == rpfb_pkg::BYTES_24BPP) begin
      merged[31:24] = 8'd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    result.packed_res  <= merged;
    result.byte_offset <= offset;
  end

  // an in-frame pixel always comes out on done after passing the valid pipe
  `ASSERT_IMPL(a_latency, accept && keep, ##4 done, "in-frame pixel lost")
  // nothing comes out on done without a matching in-frame pixel taken before
  `ASSERT_IMPL(a_no_extra, done, $past(accept && keep, 4), "result without pixel")
  // 24 bpp results carry a clear top byte
  `ASSERT_IMPL(a_top_byte, done && (cfg.out_bytes == rpfb_pkg::BYTES_24BPP),
               (result.packed_res[31:24] == 8'd0), "top byte set in 24 bpp mode")

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the pixel format blit block
// depends on rpfb_pkg and rgb_pixel_format_blit; predicts each result in place
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  rpfb_pkg::px_item_t   item = '0;
  logic                 done;
  rpfb_pkg::px_result_t result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [rpfb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rpfb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the register file, as it was written
  rpfb_pkg::cfg_t       blit_cfg;
  rpfb_pkg::px_result_t pending_results[$];
  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count = 0;
  bit                   no_gaps = 1'b0;

  rgb_pixel_format_blit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one 8-bit channel scaled to its mask size and moved into place
  function automatic logic [31:0] scale_to_mask(input logic [7:0] v, input logic [8:0] layout);
    int unsigned sz;
    int unsigned maxv;
    int unsigned sv;
    logic [31:0] field;
    sz = layout[8:5];
    if (sz == 0) return '0;
    if (sz > 8) sz = 8;
    maxv = (1 << sz) - 1;
    sv = (v * maxv) / 255;
    field = sv & maxv;
    return field << layout[4:0];
  endfunction

  // returns 1 when the pixel lands inside the frame and gives a result
  function automatic bit predict_pixel(input rpfb_pkg::px_item_t it,
                                       output rpfb_pkg::px_result_t r);
    int unsigned w;
    int unsigned h;
    logic [63:0] offs;
    r = '0;
    w = (blit_cfg.frame_width < rpfb_pkg::MAX_DIM) ? blit_cfg.frame_width : rpfb_pkg::MAX_DIM;
    h = (blit_cfg.frame_height < rpfb_pkg::MAX_DIM) ? blit_cfg.frame_height : rpfb_pkg::MAX_DIM;
    if (blit_cfg.out_bytes != rpfb_pkg::BYTES_24BPP &&
        blit_cfg.out_bytes != rpfb_pkg::BYTES_32BPP) return 1'b0;
    if (it.col >= w || it.row >= h) return 1'b0;
    r.packed_res = scale_to_mask(it.pixel[23:16], blit_cfg.red_layout)
                 | scale_to_mask(it.pixel[15:8], blit_cfg.green_layout)
                 | scale_to_mask(it.pixel[7:0], blit_cfg.blue_layout);
    if (blit_cfg.out_bytes == rpfb_pkg::BYTES_24BPP) r.packed_res[31:24] = 8'h00;
    offs = 64'(it.row) * 64'(blit_cfg.dst_pitch) + 64'(it.col) * 64'(blit_cfg.out_bytes);
    r.byte_offset = offs[27:0];
    return 1'b1;
  endfunction

  // result checker, the receiver never stalls
  always @(posedge clk) begin
    rpfb_pkg::px_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h / %h",
                 $time, result.packed_res, result.byte_offset);
        mismatch_count = mismatch_count + 1;
      end else begin
        exp_res = pending_results.pop_front();
        if (result.packed_res !== exp_res.packed_res) begin
          $display("%0t: packed_res mismatch, expected %h, actual %h",
                   $time, exp_res.packed_res, result.packed_res);
          mismatch_count = mismatch_count + 1;
        end
        if (result.byte_offset !== exp_res.byte_offset) begin
          $display("%0t: byte_offset mismatch, expected %h, actual %h",
                   $time, exp_res.byte_offset, result.byte_offset);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // send one pixel beat; start stays high afterwards for back-to-back beats
  task automatic send_pixel(input logic [31:0] px, input logic [11:0] c, input logic [11:0] r);
    rpfb_pkg::px_item_t   beat;
    rpfb_pkg::px_result_t exp_res;
    beat.pixel = px;
    beat.col = c;
    beat.row = r;
    if (!no_gaps) begin
      while ($urandom_range(99) < 38) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    item <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (predict_pixel(beat, exp_res)) pending_results.push_back(exp_res);
  endtask

  // stop sending and wait until the pipe is empty
  task automatic drain_pixels();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rpfb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rpfb_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // write every register; only called with the pipe drained
  task automatic apply_cfg(input rpfb_pkg::cfg_t c);
    write_reg(rpfb_pkg::REG_RED_LAYOUT, 16'(c.red_layout));
    write_reg(rpfb_pkg::REG_GREEN_LAYOUT, 16'(c.green_layout));
    write_reg(rpfb_pkg::REG_BLUE_LAYOUT, 16'(c.blue_layout));
    write_reg(rpfb_pkg::REG_OUT_BYTES, 16'(c.out_bytes));
    write_reg(rpfb_pkg::REG_FRAME_WIDTH, 16'(c.frame_width));
    write_reg(rpfb_pkg::REG_FRAME_HEIGHT, 16'(c.frame_height));
    write_reg(rpfb_pkg::REG_DST_PITCH, c.dst_pitch);
    cfg_valid <= 1'b0;
    blit_cfg = c;
    @(posedge clk);
  endtask

  function automatic rpfb_pkg::cfg_t make_cfg(input logic [8:0] red, input logic [8:0] green,
                                              input logic [8:0] blue, input logic [2:0] nbytes,
                                              input logic [12:0] w, input logic [12:0] h,
                                              input logic [15:0] pitch);
    rpfb_pkg::cfg_t c;
    c.red_layout = red;
    c.green_layout = green;
    c.blue_layout = blue;
    c.out_bytes = nbytes;
    c.frame_width = w;
    c.frame_height = h;
    c.dst_pitch = pitch;
    return c;
  endfunction

  // layout mostly with a sane size, sometimes any size up to fifteen
  function automatic logic [8:0] random_layout();
    if ($urandom_range(9) < 7) return {4'($urandom_range(8)), 5'($urandom_range(31))};
    return 9'($urandom_range(511));
  endfunction

  function automatic logic [12:0] random_dim();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return 13'($urandom_range(8191, 4097));
    if (pick < 8) return 13'($urandom_range(64, 1));
    return 13'($urandom_range(4096, 1));
  endfunction

  function automatic rpfb_pkg::cfg_t random_cfg();
    rpfb_pkg::cfg_t c;
    c.red_layout = random_layout();
    c.green_layout = random_layout();
    c.blue_layout = random_layout();
    if ($urandom_range(9) == 0) c.out_bytes = 3'($urandom_range(7));
    else c.out_bytes = $urandom_range(1) ? rpfb_pkg::BYTES_24BPP : rpfb_pkg::BYTES_32BPP;
    c.frame_width = random_dim();
    c.frame_height = random_dim();
    c.dst_pitch = 16'($urandom_range(65535));
    return c;
  endfunction

  // coordinate mostly inside the frame so that most beats give results
  function automatic logic [11:0] random_coord(input logic [12:0] dim);
    int unsigned lim;
    lim = (dim < rpfb_pkg::MAX_DIM) ? dim : rpfb_pkg::MAX_DIM;
    if (lim != 0 && $urandom_range(9) < 8) return 12'($urandom_range(lim - 1));
    return 12'($urandom_range(4095));
  endfunction

  // reset layout: 8-8-8 at shifts 16/8/0, 640x480, 4 bytes
  task automatic test_reset_layout();
    send_pixel(32'h0000_0000, 12'd0, 12'd0);
    send_pixel(32'hFFFF_FFFF, 12'd639, 12'd479);
    send_pixel(32'h00FF_8040, 12'd640, 12'd0);
    send_pixel(32'h1234_5678, 12'd0, 12'd480);
    send_pixel(32'hFFFF_FFFF, 12'd4095, 12'd4095);
  endtask

  // zero size, saturated size, bits shifted past the top, 3-byte mode
  task automatic test_channel_layouts();
    drain_pixels();
    apply_cfg(make_cfg(9'd511, 9'd5, 9'd32, rpfb_pkg::BYTES_24BPP, 13'd4096, 13'd4096,
                       16'hFFFF));
    send_pixel(32'h00FF_FFFF, 12'd4095, 12'd4095);
    send_pixel(32'h0080_0180, 12'd1, 12'd2);
    send_pixel(32'hFF7F_7F7F, 12'd10, 12'd10);
    drain_pixels();
    apply_cfg(make_cfg(9'd280, 9'd254, 9'd156, rpfb_pkg::BYTES_32BPP, 13'd640, 13'd480,
                       16'd2560));
    send_pixel(32'hFFFF_FFFF, 12'd3, 12'd7);
    send_pixel(32'h0001_FE7F, 12'd639, 12'd0);
    send_pixel(32'hAA55_AA55, 12'd0, 12'd479);
  endtask

  // pixel size other than 3 or 4 bytes drops every pixel
  task automatic test_bad_pixel_size();
    drain_pixels();
    apply_cfg(make_cfg(9'd272, 9'd264, 9'd256, 3'd0, 13'd640, 13'd480, 16'd2560));
    send_pixel(32'hFFFF_FFFF, 12'd0, 12'd0);
    send_pixel(32'h0012_3456, 12'd5, 12'd5);
    drain_pixels();
    apply_cfg(make_cfg(9'd272, 9'd264, 9'd256, 3'd7, 13'd640, 13'd480, 16'd2560));
    send_pixel(32'hFFFF_FFFF, 12'd1, 12'd1);
    send_pixel(32'h0065_4321, 12'd2, 12'd3);
  endtask

  // oversize frame clips at the max, empty frame clips all, zero and tiny pitch
  task automatic test_frame_edges();
    drain_pixels();
    apply_cfg(make_cfg(9'd272, 9'd264, 9'd256, rpfb_pkg::BYTES_32BPP, 13'd8191, 13'd8191,
                       16'd0));
    send_pixel(32'hFFFF_FFFF, 12'd4095, 12'd4095);
    send_pixel(32'h0000_0000, 12'd4095, 12'd0);
    drain_pixels();
    apply_cfg(make_cfg(9'd272, 9'd264, 9'd256, rpfb_pkg::BYTES_32BPP, 13'd0, 13'd480,
                       16'd2560));
    send_pixel(32'hFFFF_FFFF, 12'd0, 12'd0);
    drain_pixels();
    apply_cfg(make_cfg(9'd272, 9'd264, 9'd256, rpfb_pkg::BYTES_24BPP, 13'd1, 13'd0, 16'd1));
    send_pixel(32'h0000_0000, 12'd0, 12'd0);
    drain_pixels();
    apply_cfg(make_cfg(9'd272, 9'd264, 9'd256, rpfb_pkg::BYTES_24BPP, 13'd1, 13'd1, 16'd1));
    send_pixel(32'h00AA_BBCC, 12'd0, 12'd0);
  endtask

  // random layouts and frames, one phase without gaps, a full drain mid-phase in phase 0 and at random
  task automatic test_random_blits();
    for (int phase = 0; phase < 8; phase++) begin
      drain_pixels();
      apply_cfg(random_cfg());
      no_gaps = (phase == 2);
      for (int n = 0; n < 140; n++) begin
        if (n == 70 && (phase == 0 || $urandom_range(1) == 0)) drain_pixels();
        send_pixel($urandom, random_coord(blit_cfg.frame_width),
                   random_coord(blit_cfg.frame_height));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    blit_cfg = make_cfg(9'd272, 9'd264, 9'd256, rpfb_pkg::BYTES_32BPP, 13'd640, 13'd480,
                        16'd2560);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_layout();
    test_channel_layouts();
    test_bad_pixel_size();
    test_frame_edges();
    test_random_blits();
    drain_pixels();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/rpfb_pkg.sv
sv/rpfb_chan.sv
sv/rpfb_offs.sv
sv/rgb_pixel_format_blit.sv
tb/testbench.sv
